FILE: sv/pjt_pkg.sv
// ----------------------------------------------------------------------------
// pjt_pkg
// Types, constants and the arctangent table shared by the planar joint
// transform and its pipeline cells.
// ----------------------------------------------------------------------------
package pjt_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned CORDIC_STEPS   = 30;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // One input item: the joint variables.
  typedef struct packed {
    logic        [15:0] direction_angle;
    logic signed [31:0] slide_distance;
    logic        [15:0] relative_rotation;
  } pjt_in_t;

  // One result item: the variable entries of the transform.
  typedef struct packed {
    logic signed [15:0] cos_sum;
    logic signed [15:0] sin_sum;
    logic signed [31:0] x_translation;
    logic signed [31:0] y_translation;
  } pjt_out_t;

  // CORDIC vector and residual angle, Q2.30 and a 32-bit phase.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pjt_lane_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    pjt_lane_t          sum_lane;
    pjt_lane_t          dir_lane;
    logic        [1:0]  sum_quad;
    logic        [1:0]  dir_quad;
    logic signed [31:0] distance;
  } pjt_stage_t;

  // Arctangent of 2^-i, in units of 2^-32 turn.
  function automatic logic signed [31:0] atan_entry(input int unsigned i);
    logic signed [31:0] r;
    unique case (i)
      0:       r = 32'sd536870912;
      1:       r = 32'sd316933406;
      2:       r = 32'sd167458907;
      3:       r = 32'sd85004756;
      4:       r = 32'sd42667331;
      5:       r = 32'sd21354465;
      6:       r = 32'sd10679838;
      7:       r = 32'sd5340245;
      8:       r = 32'sd2670163;
      9:       r = 32'sd1335087;
      10:      r = 32'sd667544;
      11:      r = 32'sd333772;
      12:      r = 32'sd166886;
      13:      r = 32'sd83443;
      14:      r = 32'sd41722;
      15:      r = 32'sd20861;
      16:      r = 32'sd10430;
      17:      r = 32'sd5215;
      18:      r = 32'sd2608;
      19:      r = 32'sd1304;
      20:      r = 32'sd652;
      21:      r = 32'sd326;
      22:      r = 32'sd163;
      23:      r = 32'sd81;
      24:      r = 32'sd41;
      25:      r = 32'sd20;
      26:      r = 32'sd10;
      27:      r = 32'sd5;
      28:      r = 32'sd3;
      29:      r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/planar_joint_transform.sv
// ----------------------------------------------------------------------------
// planar_joint_transform
// Variable entries of the planar joint transform: cosine and sine of the
// summed angle and the slide translation along the direction angle.
// ----------------------------------------------------------------------------
// Usage: each input item on in_data_i carries one joint (direction angle,
// slide distance, relative rotation). It is taken at a rising edge where
// in_valid_i is high and in_stall_o is low. Each input item yields exactly
// one result item on out_data_o, taken where out_valid_o is high and
// out_stall_i is low; results leave in input order.
// On its way to out_valid_o the item passes 33 registers: the input
// stage, which loads at the accepting edge, then thirty CORDIC cells, one
// stage for the quadrant rotation and the two distance multipliers, and
// the output register with rounding and saturation. Throughput is one
// item per cycle while out_stall_i stays low, set by the cell chain that
// performs one CORDIC step per cell.
// When the receiver stalls, the result holds and empty stages ahead of it
// keep filling; in_stall_o rises only once every stage holds an item.
// Reset clears all valid flags; the block holds no other state and needs
// no clearing pass.
// ----------------------------------------------------------------------------
module planar_joint_transform #(
  parameter int unsigned ANGLE_BITS = pjt_pkg::ANGLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pjt_pkg::pjt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pjt_pkg::pjt_out_t out_data_o
);
  import pjt_pkg::*;

  logic       front_adv;
  logic       valid_c [CORDIC_STEPS+1];
  logic       adv_c   [CORDIC_STEPS+1];
  pjt_stage_t data_c  [CORDIC_STEPS+1];

  pjt_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .adv_i  (adv_c[0]),
    .adv_o  (front_adv),
    .valid_o(valid_c[0]),
    .data_o (data_c[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    pjt_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[k]),
      .data_i (data_c[k]),
      .adv_i  (adv_c[k+1]),
      .adv_o  (adv_c[k]),
      .valid_o(valid_c[k+1]),
      .data_o (data_c[k+1])
    );
  end

  pjt_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_c[CORDIC_STEPS]),
    .data_i (data_c[CORDIC_STEPS]),
    .adv_o  (adv_c[CORDIC_STEPS]),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  assign in_stall_o = !front_adv;

`ifndef SYNTHESIS
  // The input side only backs up when the result waits on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is free");

  // An accepted item is held by the input stage in the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_c[0])
    else $error("accepted item missing from the input stage");

  // A full input stage whose item the first cell cannot take keeps the input stalled.
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_c[0] && !adv_c[0]) |-> in_stall_o)
    else $error("input stage loads while its item cannot advance");

  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");
`endif

endmodule

FILE: sv/pjt_front.sv
// ----------------------------------------------------------------------------
// pjt_front
// Input stage: turns both angles into 32-bit phases, splits off the
// quadrant and seeds the two CORDIC lanes.
// ----------------------------------------------------------------------------
module pjt_front #(
  parameter int unsigned ANGLE_BITS = pjt_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pjt_pkg::pjt_in_t    data_i,
  input  logic                adv_i,
  output logic                adv_o,
  output logic                valid_o,
  output pjt_pkg::pjt_stage_t data_o
);
  import pjt_pkg::*;

  localparam int unsigned Shift = 32 - ANGLE_BITS;
  localparam logic [31:0] Mask  = 32'hFFFF_FFFF >> Shift;

  logic [31:0] phase_dir;
  logic [31:0] phase_sum;
  logic [31:0] diff_dir;
  logic [31:0] diff_sum;
  logic [31:0] rnd_dir;
  logic [31:0] rnd_sum;
  logic        valid_q;
  pjt_stage_t  data_d;
  pjt_stage_t  data_q;

  always_comb begin
    phase_dir = (32'(data_i.direction_angle) & Mask) << Shift;
    phase_sum = phase_dir + ((32'(data_i.relative_rotation) & Mask) << Shift);
    // Nearest quarter turn; the residual lies in [-1/8, 1/8) turn.
    rnd_dir   = phase_dir + 32'h2000_0000;
    rnd_sum   = phase_sum + 32'h2000_0000;
    diff_dir  = phase_dir - {rnd_dir[31:30], 30'd0};
    diff_sum  = phase_sum - {rnd_sum[31:30], 30'd0};

    data_d.dir_quad   = rnd_dir[31:30];
    data_d.sum_quad   = rnd_sum[31:30];
    data_d.dir_lane.x = CORDIC_GAIN;
    data_d.dir_lane.y = '0;
    data_d.dir_lane.z = $signed(diff_dir);
    data_d.sum_lane.x = CORDIC_GAIN;
    data_d.sum_lane.y = '0;
    data_d.sum_lane.z = $signed(diff_sum);
    data_d.distance   = data_i.slide_distance;
  end

  assign adv_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/pjt_cordic_cell.sv
// ----------------------------------------------------------------------------
// pjt_cordic_cell
// One CORDIC rotation step for both lanes, registered, with the joint
// payload carried alongside.
// ----------------------------------------------------------------------------
module pjt_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pjt_pkg::pjt_stage_t data_i,
  input  logic                adv_i,
  output logic                adv_o,
  output logic                valid_o,
  output pjt_pkg::pjt_stage_t data_o
);
  import pjt_pkg::*;

  localparam logic signed [31:0] Atan = atan_entry(STEP);

  logic       valid_q;
  pjt_stage_t data_d;
  pjt_stage_t data_q;

  // Arithmetic shifts on signed values round toward minus infinity.
  function automatic pjt_lane_t rotate(input pjt_lane_t l);
    pjt_lane_t r;
    if (!l.z[31]) begin
      r.x = l.x - (l.y >>> STEP);
      r.y = l.y + (l.x >>> STEP);
      r.z = l.z - Atan;
    end else begin
      r.x = l.x + (l.y >>> STEP);
      r.y = l.y - (l.x >>> STEP);
      r.z = l.z + Atan;
    end
    return r;
  endfunction

  always_comb begin
    data_d          = data_i;
    data_d.sum_lane = rotate(data_i.sum_lane);
    data_d.dir_lane = rotate(data_i.dir_lane);
  end

  assign adv_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/pjt_back.sv
// ----------------------------------------------------------------------------
// pjt_back
// Output stages: quadrant rotation and distance products, then rounding
// and saturation into the result register.
// ----------------------------------------------------------------------------
module pjt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pjt_pkg::pjt_stage_t data_i,
  output logic                adv_o,
  input  logic                stall_i,
  output logic                valid_o,
  output pjt_pkg::pjt_out_t   data_o
);
  import pjt_pkg::*;

  logic signed [31:0] c_sum;
  logic signed [31:0] s_sum;
  logic signed [31:0] c_dir;
  logic signed [31:0] s_dir;
  logic signed [31:0] c_sum_q;
  logic signed [31:0] s_sum_q;
  logic signed [63:0] px_d;
  logic signed [63:0] py_d;
  logic signed [63:0] px_q;
  logic signed [63:0] py_q;
  logic               mid_valid_q;
  logic               out_valid_q;
  logic               adv_mid;
  logic               adv_out;
  pjt_out_t           out_d;
  pjt_out_t           out_q;

  // Exact rotation of the CORDIC pair by a multiple of a quarter turn.
  function automatic logic signed [63:0] quad_pair(input logic [1:0] q,
                                                   input pjt_lane_t l);
    logic signed [31:0] c;
    logic signed [31:0] s;
    unique case (q)
      2'd0: begin c = l.x;  s = l.y;  end
      2'd1: begin c = -l.y; s = l.x;  end
      2'd2: begin c = -l.x; s = -l.y; end
      default: begin c = l.y;  s = -l.x; end
    endcase
    return {c, s};
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] r;
    logic signed [17:0] t;
    logic signed [15:0] o;
    r = 33'(v) + 33'sd16384;
    t = 18'(r >>> 15);
    if (t > 18'sd32767) begin
      o = 16'sh7FFF;
    end else if (t < -18'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = 16'(t);
    end
    return o;
  endfunction

  function automatic logic signed [31:0] to_q16(input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [33:0] t;
    logic signed [31:0] o;
    r = p + 64'sd536870912;
    t = 34'(r >>> 30);
    if (t > 34'sd2147483647) begin
      o = 32'sh7FFF_FFFF;
    end else if (t < -34'sd2147483648) begin
      o = 32'sh8000_0000;
    end else begin
      o = 32'(t);
    end
    return o;
  endfunction

  always_comb begin
    {c_sum, s_sum} = quad_pair(data_i.sum_quad, data_i.sum_lane);
    {c_dir, s_dir} = quad_pair(data_i.dir_quad, data_i.dir_lane);
    px_d = 64'(data_i.distance) * 64'(c_dir);
    py_d = 64'(data_i.distance) * 64'(s_dir);
  end

  always_comb begin
    out_d.cos_sum       = to_q15(c_sum_q);
    out_d.sin_sum       = to_q15(s_sum_q);
    out_d.x_translation = to_q16(px_q);
    out_d.y_translation = to_q16(py_q);
  end

  assign adv_out = !out_valid_q || !stall_i;
  assign adv_mid = !mid_valid_q || adv_out;
  assign adv_o   = adv_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_mid) begin
        mid_valid_q <= valid_i;
      end
      if (adv_out) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_mid && valid_i) begin
      c_sum_q <= c_sum;
      s_sum_q <= s_sum;
      px_q    <= px_d;
      py_q    <= py_d;
    end
    if (adv_out && mid_valid_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
